// File: hdl/sm3_hash_core_defines.svh
// ----------------------------------------------------------------------------
// SM3 hash core assertion macros
// Shared property macros for the checker that watches the core's ports.
// ----------------------------------------------------------------------------
`ifndef SM3_HASH_CORE_DEFINES_SVH
`define SM3_HASH_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SM3_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sm3_hash_core port check failed");

// The consequent must hold in the cycle after the antecedent.
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sm3_hash_core port check failed");

`endif

// File: hdl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 package
// Types and fixed constants shared by the SM3 hash core files.
// ----------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

   typedef logic [31:0]      word_type;
   typedef logic [7:0][31:0] cv_type;

   typedef struct packed {
      logic     shift_en;
      word_type shift_word;
      logic     start;
      logic     cv_init;
   } ctl_type;

   localparam cv_type SM3_IV = {
      32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
      32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
   };

   localparam word_type T_LOW      = 32'h79CC4519;
   localparam word_type T_HIGH_R16 = 32'h9D8A7A87;
   localparam word_type PAD_WORD   = 32'h80000000;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [5:0] ROUND_LAST     = 6'd63;
   localparam logic [5:0] ROUND_LOW_LAST = 6'd15;

endpackage

`default_nettype wire

// File: hdl/sm3_if.sv
// ----------------------------------------------------------------------------
// SM3 stream interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  valid_bytes;
   logic        last_word;

   modport source (output valid, message_word, valid_bytes, last_word, input ready);
   modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        digest_end;

   modport source (output valid, digest_word, digest_end, input ready);
   modport sink   (input valid, digest_word, digest_end, output ready);
endinterface

`default_nettype wire

// File: hdl/sm3_compress.sv
// ----------------------------------------------------------------------------
// SM3 compression unit
// Sixteen-word schedule window, one round per cycle, feed-forward into the
// chaining value at the end of round 63.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_compress (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sm3_pkg::ctl_type ctl,
   output logic                  busy,
   output sm3_pkg::cv_type       cv
);
   import sm3_pkg::*;

   function automatic word_type rotl(word_type x, int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic word_type perm0(word_type x);
      return x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic word_type perm1(word_type x);
      return x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

   logic [15:0][31:0] w_ff, w_in;
   cv_type            v_ff, v_in, v_new;
   cv_type            cv_ff, cv_in;
   word_type          t_ff, t_in;
   logic [5:0]        round_ff, round_in;
   logic              busy_ff, busy_in;

   word_type a12, ss1, ss2, ffv, ggv, tt1, tt2, w_next;

   always_comb begin
      a12 = rotl(v_ff[0], 12);
      ss1 = rotl(a12 + v_ff[4] + t_ff, 7);
      ss2 = ss1 ^ a12;
      if (round_ff <= ROUND_LOW_LAST) begin
         ffv = v_ff[0] ^ v_ff[1] ^ v_ff[2];
         ggv = v_ff[4] ^ v_ff[5] ^ v_ff[6];
      end else begin
         ffv = (v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]);
         ggv = (v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]);
      end
      tt1 = ffv + v_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = ggv + v_ff[7] + ss1 + w_ff[0];
      v_new[0] = tt1;
      v_new[1] = v_ff[0];
      v_new[2] = rotl(v_ff[1], 9);
      v_new[3] = v_ff[2];
      v_new[4] = perm0(tt2);
      v_new[5] = v_ff[4];
      v_new[6] = rotl(v_ff[5], 19);
      v_new[7] = v_ff[6];
      w_next = perm1(w_ff[0] ^ w_ff[7] ^ rotl(w_ff[13], 15))
               ^ rotl(w_ff[3], 7) ^ w_ff[10];
   end

   always_comb begin
      w_in     = w_ff;
      v_in     = v_ff;
      cv_in    = cv_ff;
      t_in     = t_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      if (ctl.cv_init) begin
         cv_in = SM3_IV;
      end
      if (ctl.shift_en) begin
         w_in = {ctl.shift_word, w_ff[15:1]};
      end
      if (ctl.start) begin
         busy_in  = 1'b1;
         round_in = '0;
         v_in     = cv_ff;
         t_in     = T_LOW;
      end else if (busy_ff) begin
         v_in     = v_new;
         w_in     = {w_next, w_ff[15:1]};
         round_in = round_ff + 6'd1;
         t_in     = (round_ff == ROUND_LOW_LAST) ? T_HIGH_R16 : rotl(t_ff, 1);
         if (round_ff == ROUND_LAST) begin
            busy_in = 1'b0;
            cv_in   = cv_ff ^ v_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      t_ff <= t_in;
      if (reset) begin
         cv_ff    <= SM3_IV;
         round_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         cv_ff    <= cv_in;
         round_ff <= round_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign cv   = cv_ff;

endmodule

`default_nettype wire

// File: hdl/sm3_hash_core.sv
// ----------------------------------------------------------------------------
// SM3 hash core
// Streaming SM3 hash of one message at a time with padding and digest output.
// ----------------------------------------------------------------------------
//   Channel   Dir   Contents
//   req_bus   in    message_word[31:0], valid_bytes[2:0], last_word
//   rsp_bus   out   digest_word[31:0], digest_end
//
// A word other than the last that does not fill a block leaves the input ready.
// A word that fills a block holds off the input while the
// compression unit runs its 64 rounds, one per cycle.
// A last word adds padding words, the bit length and one or two such compressions,
// then eight digest transactions that wait on rsp_bus.ready.
// Reset returns the chaining value to the initial value.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_hash_core (
   input  wire logic clock,
   input  wire logic reset,
   sm3_req_if.sink   req_bus,
   sm3_rsp_if.source rsp_bus
);
   import sm3_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_COMP = 3'd1;
   localparam logic [2:0] ST_PAD  = 3'd2;
   localparam logic [2:0] ST_ZERO = 3'd3;
   localparam logic [2:0] ST_LENH = 3'd4;
   localparam logic [2:0] ST_LENL = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   localparam logic [3:0] CNT_LAST = 4'd15;
   localparam logic [3:0] CNT_LEN  = 4'd14;
   localparam logic [2:0] IDX_LAST = 3'd7;
   localparam logic [2:0] VB_FULL  = 3'd4;

   logic [2:0]  state_ff, state_in, ret_ff, ret_in, after;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] bits_ff, bits_in;
   logic [2:0]  idx_ff, idx_in;

   ctl_type  ctl;
   logic     busy;
   cv_type   cv;
   logic     req_fire, rsp_fire;
   logic [2:0] vb;
   word_type keep, pad, merged;

   sm3_compress u_compress (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .busy  (busy),
      .cv    (cv)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = (state_ff == ST_OUT);
   assign rsp_bus.digest_word = cv[idx_ff];
   assign rsp_bus.digest_end  = (idx_ff == IDX_LAST);

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      vb = (req_bus.valid_bytes inside {[3'd5:3'd7]}) ? VB_FULL : req_bus.valid_bytes;
      case (vb)
         3'd1: begin
            keep = 32'hFF000000;
            pad  = {8'h00, PAD_BYTE, 16'h0000};
         end
         3'd2: begin
            keep = 32'hFFFF0000;
            pad  = {16'h0000, PAD_BYTE, 8'h00};
         end
         3'd3: begin
            keep = 32'hFFFFFF00;
            pad  = {24'h000000, PAD_BYTE};
         end
         default: begin
            keep = 32'h00000000;
            pad  = PAD_WORD;
         end
      endcase
      merged = (req_bus.message_word & keep) | pad;
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cnt_in   = cnt_ff;
      bits_in  = bits_ff;
      idx_in   = idx_ff;
      after    = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ctl.shift_en = 1'b1;
               if (!req_bus.last_word) begin
                  ctl.shift_word = req_bus.message_word;
                  bits_in        = bits_ff + 64'd32;
                  after          = ST_IDLE;
               end else begin
                  bits_in = bits_ff + {58'd0, vb, 3'b000};
                  if (vb == VB_FULL) begin
                     ctl.shift_word = req_bus.message_word;
                     after          = ST_PAD;
                  end else begin
                     ctl.shift_word = merged;
                     after          = ST_ZERO;
                  end
               end
            end
         end
         ST_COMP: begin
            if (!busy) begin
               state_in = ret_ff;
            end
         end
         ST_PAD: begin
            ctl.shift_en   = 1'b1;
            ctl.shift_word = PAD_WORD;
            after          = ST_ZERO;
         end
         ST_ZERO: begin
            if (cnt_ff == CNT_LEN) begin
               state_in = ST_LENH;
            end else begin
               ctl.shift_en   = 1'b1;
               ctl.shift_word = '0;
               after          = ST_ZERO;
            end
         end
         ST_LENH: begin
            ctl.shift_en   = 1'b1;
            ctl.shift_word = bits_ff[63:32];
            after          = ST_LENL;
         end
         ST_LENL: begin
            ctl.shift_en   = 1'b1;
            ctl.shift_word = bits_ff[31:0];
            after          = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (idx_ff == IDX_LAST) begin
                  idx_in      = '0;
                  ctl.cv_init = 1'b1;
                  bits_in     = '0;
                  cnt_in      = '0;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (ctl.shift_en) begin
         if (cnt_ff == CNT_LAST) begin
            cnt_in    = '0;
            ctl.start = 1'b1;
            ret_in    = after;
            state_in  = ST_COMP;
         end else begin
            cnt_in   = cnt_ff + 4'd1;
            state_in = after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         cnt_ff   <= '0;
         bits_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
         bits_ff  <= bits_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/sm3_hash_core_checker.sv
// ----------------------------------------------------------------------------
// SM3 hash core checker
// Port-level properties of the hash core, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sm3_hash_core_defines.svh"

module sm3_hash_core_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last_word,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic        rsp_digest_end
);

   `SM3_ASSERT_NOW(a_no_input_during_output, clock, reset, rsp_valid, !req_ready)
   `SM3_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_digest_end))
   `SM3_ASSERT_NEXT(a_end_returns_idle, clock, reset, rsp_valid && rsp_ready && rsp_digest_end, !rsp_valid && req_ready)
   `SM3_ASSERT_NEXT(a_plain_word_no_digest, clock, reset, req_valid && req_ready && !req_last_word, !rsp_valid)
   `SM3_ASSERT_NEXT(a_last_word_busy, clock, reset, req_valid && req_ready && req_last_word, !req_ready)

endmodule

bind sm3_hash_core sm3_hash_core_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_last_word   (req_bus.last_word),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_digest_word (rsp_bus.digest_word),
   .rsp_digest_end  (rsp_bus.digest_end)
);

`default_nettype wire
